[rtl/core/sevt_pkg.sv]
package sevt_pkg;

  localparam int unsigned FieldW = 16;
  localparam int unsigned TempW  = 14;
  localparam int unsigned ProdW  = 2 * FieldW;
  // available water scaled by 65536, 0.01 mm units: 32 bit product times 100
  localparam int unsigned AvailW = ProdW + 7;
  // root depth times 100
  localparam int unsigned DepthW = FieldW + 7;
  // evaporation shifted up 16 plus half the depth divisor
  localparam int unsigned NumW   = ProdW + 1;

  // side data carried through the linear scaling divider
  typedef struct packed {
    logic              bypass;
    logic              full;
    logic [FieldW-1:0] demand;
    logic [AvailW-1:0] avail;
    logic [DepthW-1:0] divr;
    logic [FieldW-1:0] moist;
    logic [FieldW-1:0] wp;
  } mid_t;

  // side data carried through the moisture decrement divider
  typedef struct packed {
    logic              zero;
    logic              cap;
    logic [FieldW-1:0] soil_et;
    logic [FieldW-1:0] moist;
    logic [FieldW-1:0] wp;
  } tail_t;

  // multiply by 100 as shifts and adds
  function automatic logic [AvailW-1:0] mul100(input logic [ProdW-1:0] x);
    logic [AvailW-1:0] xe;
    xe = AvailW'(x);
    return (xe << 6) + (xe << 5) + (xe << 2);
  endfunction

endpackage

[rtl/core/soil_evapotranspiration_step_unit.sv]
// Soil evaporation and moisture update, one grid cell per word. A new word
// is taken every cycle while the output side keeps taking words; the depth
// comes from two 16 stage pipelined dividers (linear scaling between
// wilting point and field capacity, then the moisture decrement) plus five
// stages of multiply, compare and select. The whole pipeline holds while a
// result waits at the output. Frozen soil and soil below wilting point give
// zero evaporation and pass moisture through; evaporation is capped at the
// water held above wilting point over the root depth.
module soil_evapotranspiration_step_unit
  import sevt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [13:0]  cfg_wdata,   // frozen_threshold
  input  logic         s_tvalid,
  output logic         s_tready,
  // field_capacity, wilting_point, root_depth, interception_et, potential_et,
  // depression_et, soil_moisture, soil_temperature, 2 zero bits
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // soil_et, new_soil_moisture
  output logic [31:0]  m_tdata
);

  logic              adv;
  logic [TempW-1:0]  frozen_threshold;

  logic [FieldW-1:0] in_fc, in_wp, in_depth, in_ei, in_pet, in_ed, in_moist;
  logic [TempW-1:0]  in_temp;
  logic [FieldW+1:0] in_rest;

  logic              a_valid, a_bypass, a_full;
  logic [FieldW-1:0] a_demand, a_diff, a_fcwp, a_depth, a_moist, a_wp;

  logic              b_valid, b_bypass, b_full;
  logic [FieldW-1:0] b_demand, b_fcwp, b_depth, b_moist, b_wp;
  logic [ProdW-1:0]  b_prod, b_avraw;

  logic              c_valid;
  logic [ProdW-1:0]  c_prod;
  logic [FieldW-1:0] c_fcwp;
  mid_t              c_side;

  logic              d1_valid;
  logic [FieldW-1:0] q1;
  mid_t              d1_side;

  logic [FieldW-1:0] et0;
  logic              cap0;
  logic [NumW-1:0]   num0;

  logic              d_valid;
  logic [NumW-1:0]   d_num;
  logic [DepthW-1:0] d_divr;
  tail_t             d_side;

  logic              d2_valid;
  logic [FieldW-1:0] q2;
  tail_t             d2_side;

  logic [FieldW-1:0] out_et, out_moist;

  // the pipeline moves whenever the output register is free
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      frozen_threshold <= '0;
    end else if (cfg_we) begin
      frozen_threshold <= cfg_wdata;
    end
  end

  // unpack the input word
  assign in_fc    = s_tdata[15:0];
  assign in_wp    = s_tdata[31:16];
  assign in_depth = s_tdata[47:32];
  assign in_ei    = s_tdata[63:48];
  assign in_pet   = s_tdata[79:64];
  assign in_ed    = s_tdata[95:80];
  assign in_moist = s_tdata[111:96];
  assign in_temp  = s_tdata[125:112];
  assign in_rest  = {2'b00, in_pet} - {2'b00, in_ei} - {2'b00, in_ed};

  // stage a: special cases, remaining demand, moisture differences
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_bypass <= ($signed(in_temp) <= $signed(frozen_threshold)) || (in_moist < in_wp);
      a_full   <= in_moist >= in_fc;
      a_demand <= in_rest[FieldW+1] ? '0 : in_rest[FieldW-1:0];
      a_diff   <= in_moist - in_wp;
      a_fcwp   <= in_fc - in_wp;
      a_depth  <= in_depth;
      a_moist  <= in_moist;
      a_wp     <= in_wp;
    end
  end

  // stage b: scaling product and available water product
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_bypass <= a_bypass;
      b_full   <= a_full;
      b_demand <= a_demand;
      b_fcwp   <= a_fcwp;
      b_depth  <= a_depth;
      b_moist  <= a_moist;
      b_wp     <= a_wp;
      b_prod   <= a_demand * a_diff;
      b_avraw  <= a_diff * a_depth;
    end
  end

  // stage c: scale to 0.01 mm
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_prod        <= b_prod;
      c_fcwp        <= b_fcwp;
      c_side.bypass <= b_bypass;
      c_side.full   <= b_full;
      c_side.demand <= b_demand;
      c_side.avail  <= mul100(b_avraw);
      c_side.divr   <= DepthW'(mul100(ProdW'(b_depth)));
      c_side.moist  <= b_moist;
      c_side.wp     <= b_wp;
    end
  end

  // demand * (moist - wp) / (fc - wp)
  sevt_div #(
    .DW (FieldW),
    .QW (FieldW),
    .SW ($bits(mid_t))
  ) u_scale_div (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (c_valid),
    .in_dividend (c_prod),
    .in_divisor  (c_fcwp),
    .in_side     (c_side),
    .out_valid   (d1_valid),
    .out_quot    (q1),
    .out_side    (d1_side)
  );

  // evaporation before the cap, cap test and rounded decrement numerator
  assign et0  = d1_side.bypass ? '0 : (d1_side.full ? d1_side.demand : q1);
  assign cap0 = AvailW'({et0, 16'h0000}) > d1_side.avail;
  assign num0 = NumW'({et0, 16'h0000}) + NumW'(d1_side.divr >> 1);

  // stage d
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_num          <= num0;
      d_divr         <= d1_side.divr;
      d_side.zero    <= et0 == '0;
      d_side.cap     <= cap0;
      d_side.soil_et <= cap0 ? d1_side.avail[ProdW-1:16] : et0;
      d_side.moist   <= d1_side.moist;
      d_side.wp      <= d1_side.wp;
    end
  end

  // (et * 65536 + depth * 50) / (depth * 100)
  sevt_div #(
    .DW (DepthW),
    .QW (FieldW),
    .SW ($bits(tail_t))
  ) u_dec_div (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (d_valid),
    .in_dividend ((DepthW + FieldW)'(d_num)),
    .in_divisor  (d_divr),
    .in_side     (d_side),
    .out_valid   (d2_valid),
    .out_quot    (q2),
    .out_side    (d2_side)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_et    <= d2_side.zero ? '0 : d2_side.soil_et;
      out_moist <= d2_side.zero ? d2_side.moist :
                   (d2_side.cap ? d2_side.wp : d2_side.moist - q2);
    end
  end

  assign m_tdata = {out_moist, out_et};

`ifndef NO_ASSERTIONS
  // scaled evaporation never exceeds the demand
  a_scale_bound: assert property (@(posedge clk) disable iff (rst)
    d1_valid && !d1_side.bypass && !d1_side.full |-> q1 <= d1_side.demand)
    else $error("scaled evaporation above demand");

  // moisture decrement never drives moisture below zero
  a_dec_bound: assert property (@(posedge clk) disable iff (rst)
    d2_valid && !d2_side.zero && !d2_side.cap |-> q2 <= d2_side.moist)
    else $error("moisture decrement above moisture");

  // a held output freezes the valid bits of stages a, c and d
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(a_valid) && $stable(c_valid) && $stable(d_valid))
    else $error("pipeline moved during a stall");
`endif

endmodule

[rtl/core/sevt_div.sv]
module sevt_div #(
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 16,
  parameter int unsigned SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DW+QW-1:0] in_dividend,
  input  logic [DW-1:0]    in_divisor,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [QW-1:0]    out_quot,
  output logic [SW-1:0]    out_side
);

  // one quotient bit per stage, index 0 is the unregistered input
  logic          vld  [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [QW-1:0] lo   [0:QW];
  logic [QW-1:0] quo  [0:QW];
  logic [DW-1:0] dsr  [0:QW];
  logic [SW-1:0] side [0:QW];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_dividend[DW+QW-1:QW];
  assign lo[0]   = in_dividend[QW-1:0];
  assign quo[0]  = '0;
  assign dsr[0]  = in_divisor;
  assign side[0] = in_side;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] sub;
    logic        ge;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem[i], lo[i][QW-1]};
    assign sub   = trial - {1'b0, dsr[i]};
    assign ge    = trial >= {1'b0, dsr[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? sub[DW-1:0] : trial[DW-1:0];
        lo[i+1]   <= lo[i] << 1;
        quo[i+1]  <= (quo[i] << 1) | QW'(ge);
        dsr[i+1]  <= dsr[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quot  = quo[QW];
  assign out_side  = side[QW];

endmodule
